>>> rtl/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg: shared definitions for the fixed-point decimal formatter
// Field widths, ASCII codes and divide-by-ten reciprocal constants.
// ----------------------------------------------------------------------------
package fpdf_pkg;

	localparam int VALUE_W          = 32;
	localparam int DEC_W            = 4;
	localparam int CHAR_W           = 8;
	localparam int DIGIT_BUFFER_DEF = 12;
	localparam int MAX_DECIMALS     = 10;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [VALUE_W-1:0] MAG_MAX = 32'h7FFF_FFFF;

	// q = (a * RECIP) >> RECIP_SHIFT equals a / 10 for every 32-bit a
	localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

endpackage

>>> rtl/fpdf_in_if.sv
// ----------------------------------------------------------------------------
// fpdf_in_if: number request channel
// Carries one signed value and its count of decimal places.
// ----------------------------------------------------------------------------
interface fpdf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [fpdf_pkg::VALUE_W-1:0] value;
	logic        [fpdf_pkg::DEC_W-1:0]   decimals;

	modport source(output valid, output value, output decimals, input ready);
	modport sink(input valid, input value, input decimals, output ready);
endinterface

>>> rtl/fpdf_out_if.sv
// ----------------------------------------------------------------------------
// fpdf_out_if: character request channel
// Carries one ASCII character and an end-of-number flag.
// ----------------------------------------------------------------------------
interface fpdf_out_if;
	logic                         valid;
	logic                         ready;
	logic [fpdf_pkg::CHAR_W-1:0]  char_out;
	logic                         last;

	modport source(output valid, output char_out, output last, input ready);
	modport sink(input valid, input char_out, input last, output ready);
endinterface

>>> rtl/fixed_point_decimal_formatter_top.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_top: signed fixed-point to ASCII formatter
//
// number (sink): one request holds a signed 32-bit value and a count of
// decimal places (saturated to ten). chars (source): the text of the
// number, one character per request: a sign (space or minus), then the
// decimal digits most significant first with a point before the last
// "decimals" digits, zero padded to at least one integer digit (two
// digits when decimals is zero). last marks the final character.
// The most negative input prints as -2147483647.
//
// One number at a time: after a request is taken, number.ready stays low
// while one shared divide-by-ten unit peels off digits (registered
// multiply, then remainder), with a separate step for the point, then the
// sign is sent, then the remaining characters one per cycle while chars
// does not stall. Longest case: decimals ten with a ten-digit value (13
// characters). A stall on chars holds the character register and the
// sequencer; the final character may still wait while a new number is
// taken. Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_top #(
	parameter int DIGIT_BUFFER = fpdf_pkg::DIGIT_BUFFER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fpdf_in_if.sink    number,
	fpdf_out_if.source chars
);

	localparam int NW = $clog2(DIGIT_BUFFER + 1);
	localparam int IW = $clog2(DIGIT_BUFFER);
	localparam int DEC_LIM_I = (fpdf_pkg::MAX_DECIMALS < DIGIT_BUFFER - 2) ?
		fpdf_pkg::MAX_DECIMALS : DIGIT_BUFFER - 2;
	localparam logic [fpdf_pkg::DEC_W-1:0] DEC_LIM = fpdf_pkg::DEC_W'(DEC_LIM_I);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIG  = 3'd2;
	localparam logic [2:0] S_PNT  = 3'd3;
	localparam logic [2:0] S_SIGN = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]                         state_q;
	logic                               neg_q;
	logic [fpdf_pkg::VALUE_W-1:0]       mag_q;
	logic [fpdf_pkg::DEC_W-1:0]         dec_q;
	logic [NW-1:0]                      n_q;
	logic [fpdf_pkg::CHAR_W-1:0]        buf_q [DIGIT_BUFFER];
	logic                               oval_q;
	logic [fpdf_pkg::CHAR_W-1:0]        ochar_q;
	logic                               olast_q;

	logic [fpdf_pkg::VALUE_W-1:0]       q;
	logic [3:0]                         r;
	logic [NW-1:0]                      n_inc;
	logic [NW-1:0]                      n_dec;
	logic [NW-1:0]                      dec_ext;
	logic [NW-1:0]                      dec_p2;
	logic [fpdf_pkg::VALUE_W-1:0]       cont_mag;
	logic                               cont;
	logic                               put_pnt;
	logic                               out_free;
	logic                               in_acc;
	logic [fpdf_pkg::VALUE_W-1:0]       raw;
	logic [fpdf_pkg::VALUE_W-1:0]       neg_mag;

	fpdf_div10 u_div10 (
		.clk (clk),
		.ld  (state_q == S_MUL),
		.a   (mag_q),
		.q   (q),
		.r   (r)
	);

	assign number.ready = (state_q == S_IDLE);
	assign in_acc       = number.valid && number.ready;
	assign raw          = fpdf_pkg::VALUE_W'(number.value);
	assign neg_mag      = (raw == ~fpdf_pkg::MAG_MAX) ? fpdf_pkg::MAG_MAX : (~raw + 1'b1);

	assign n_inc    = n_q + NW'(1);
	assign n_dec    = n_q - NW'(1);
	assign dec_ext  = NW'(dec_q);
	assign dec_p2   = dec_ext + NW'(2);
	assign cont_mag = (state_q == S_DIG) ? q : mag_q;
	assign cont     = ((cont_mag != '0) || (n_inc < dec_p2)) && (n_inc < NW'(DIGIT_BUFFER));
	assign put_pnt  = (n_inc == dec_ext) && (n_inc < NW'(DIGIT_BUFFER));
	assign out_free = !oval_q || chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			oval_q  <= 1'b0;
		end else begin
			if ((state_q == S_SIGN || state_q == S_EMIT) && out_free)
				oval_q <= 1'b1;
			else if (chars.ready)
				oval_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIG;
				end
				S_DIG: begin
					if (put_pnt)
						state_q <= S_PNT;
					else if (cont)
						state_q <= S_MUL;
					else
						state_q <= S_SIGN;
				end
				S_PNT: begin
					state_q <= cont ? S_MUL : S_SIGN;
				end
				S_SIGN: begin
					if (out_free)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free && n_q == NW'(1))
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					neg_q <= raw[fpdf_pkg::VALUE_W-1];
					mag_q <= raw[fpdf_pkg::VALUE_W-1] ? neg_mag : raw;
					dec_q <= (number.decimals > DEC_LIM) ? DEC_LIM : number.decimals;
					n_q   <= '0;
				end
			end
			S_DIG: begin
				buf_q[n_q[IW-1:0]] <= fpdf_pkg::CH_ZERO + fpdf_pkg::CHAR_W'(r);
				mag_q              <= q;
				n_q                <= n_inc;
			end
			S_PNT: begin
				buf_q[n_q[IW-1:0]] <= fpdf_pkg::CH_POINT;
				n_q                <= n_inc;
			end
			S_SIGN: begin
				if (out_free) begin
					ochar_q <= neg_q ? fpdf_pkg::CH_MINUS : fpdf_pkg::CH_SPACE;
					olast_q <= 1'b0;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					ochar_q <= buf_q[n_dec[IW-1:0]];
					olast_q <= (n_q == NW'(1));
					n_q     <= n_dec;
				end
			end
			default: begin
			end
		endcase
	end

	assign chars.valid    = oval_q;
	assign chars.char_out = ochar_q;
	assign chars.last     = olast_q;

endmodule

>>> rtl/fpdf_div10.sv
// ----------------------------------------------------------------------------
// fpdf_div10: shared divide-by-ten unit
// Registered reciprocal multiply; quotient and remainder are combinational from the registered product.
// ----------------------------------------------------------------------------
module fpdf_div10 (
	input  logic                          clk,
	input  logic                          ld,
	input  logic [fpdf_pkg::VALUE_W-1:0]  a,
	output logic [fpdf_pkg::VALUE_W-1:0]  q,
	output logic [3:0]                    r
);

	localparam int PW = 2 * fpdf_pkg::VALUE_W;

	logic [PW-1:0]                 prod_s1;
	logic [fpdf_pkg::VALUE_W-1:0]  a_s1;
	logic [fpdf_pkg::VALUE_W-1:0]  q10;
	logic [fpdf_pkg::VALUE_W-1:0]  rem;

	always_ff @(posedge clk) begin
		if (ld) begin
			prod_s1 <= PW'(a) * PW'(fpdf_pkg::RECIP);
			a_s1    <= a;
		end
	end

	assign q   = fpdf_pkg::VALUE_W'(prod_s1[PW-1:fpdf_pkg::RECIP_SHIFT]);
	assign q10 = (q << 3) + (q << 1);
	assign rem = a_s1 - q10;
	assign r   = rem[3:0];

endmodule

>>> rtl/fpdf_checker.sv
// ----------------------------------------------------------------------------
// fpdf_checker: port-level checks for the decimal formatter
// Watches both channels; bound to the top level below.
// ----------------------------------------------------------------------------
module fpdf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fpdf_pkg::CHAR_W-1:0]  char_out,
	input logic                         last
);

	logic is_digit;
	assign is_digit = (char_out >= fpdf_pkg::CH_ZERO) && (char_out <= fpdf_pkg::CH_NINE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last))
		else $error("character changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new number taken while formatting");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("ready for a number before its text is out");

	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> is_digit)
		else $error("final character is not a digit");

	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_digit || char_out == fpdf_pkg::CH_POINT ||
			char_out == fpdf_pkg::CH_MINUS || char_out == fpdf_pkg::CH_SPACE)
		else $error("character outside the output set");

endmodule

bind fixed_point_decimal_formatter_top fpdf_checker u_fpdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (number.valid),
	.in_ready  (number.ready),
	.out_valid (chars.valid),
	.out_ready (chars.ready),
	.char_out  (chars.char_out),
	.last      (chars.last)
);

>>> tb/sv/fixed_point_decimal_formatter_top_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_top_tb: self-checking bench for the formatter
// Sends signed values with decimal place counts, predicts the ASCII text
// (sign, zero-padded digits, point) per request and checks every character
// and its last flag in order, under several sender and receiver idle mixes
// and one long receiver hold-off that backs up the number channel.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_top_tb;

	localparam int RUN_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [fpdf_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} char_t;

	logic clk = 1'b0;
	logic arst_n;

	fpdf_in_if  num_if();
	fpdf_out_if chr_if();

	fixed_point_decimal_formatter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.number (num_if),
		.chars  (chr_if)
	);

	char_t expected_chars[$];
	int    fail_cnt = 0;
	int    cycle_cnt = 0;
	int    in_idle_pct = 0;
	int    out_stall_pct = 0;
	int    hold_req = 0;
	int    hold_len = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("fixed_point_decimal_formatter_top: mismatch");
			$finish;
		end
	end

	// Expected text of one number: sign, then digits MSB first with the point
	function automatic void predict_text(logic signed [fpdf_pkg::VALUE_W-1:0] v,
		logic [fpdf_pkg::DEC_W-1:0] d);
		logic [fpdf_pkg::VALUE_W-1:0] mag;
		logic [fpdf_pkg::CHAR_W-1:0]  digits [fpdf_pkg::DIGIT_BUFFER_DEF];
		int                           places;
		int                           n;
		places = (d > fpdf_pkg::MAX_DECIMALS) ? fpdf_pkg::MAX_DECIMALS : int'(d);
		if (v[fpdf_pkg::VALUE_W-1]) begin
			mag = ~v + 32'd1;
			if (mag > fpdf_pkg::MAG_MAX)
				mag = fpdf_pkg::MAG_MAX;
		end else begin
			mag = v;
		end
		n = 0;
		do begin
			digits[n] = fpdf_pkg::CH_ZERO + fpdf_pkg::CHAR_W'(mag % 10);
			mag = mag / 10;
			n++;
			if (n == places && n < fpdf_pkg::DIGIT_BUFFER_DEF) begin
				digits[n] = fpdf_pkg::CH_POINT;
				n++;
			end
		end while ((mag != 0 || n < places + 2) && n < fpdf_pkg::DIGIT_BUFFER_DEF);
		expected_chars.push_back('{ch: v[fpdf_pkg::VALUE_W-1] ? fpdf_pkg::CH_MINUS :
			fpdf_pkg::CH_SPACE, last: 1'b0});
		for (int k = n; k > 0; k--)
			expected_chars.push_back('{ch: digits[k-1], last: (k == 1)});
	endfunction

	// valid stays high between back-to-back requests
	task automatic send_number(logic signed [fpdf_pkg::VALUE_W-1:0] v,
		logic [fpdf_pkg::DEC_W-1:0] d);
		while ($urandom_range(99) < in_idle_pct) begin
			num_if.valid <= 1'b0;
			@(posedge clk);
		end
		num_if.valid    <= 1'b1;
		num_if.value    <= v;
		num_if.decimals <= d;
		@(posedge clk);
		while (!num_if.ready)
			@(posedge clk);
		predict_text(v, d);
	endtask

	function automatic logic [fpdf_pkg::VALUE_W-1:0] rand_value();
		logic [fpdf_pkg::VALUE_W-1:0] v;
		logic [fpdf_pkg::VALUE_W-1:0] p;
		int                           kind;
		kind = $urandom_range(4);
		p = 1;
		case (kind)
			0: v = $urandom;
			1: v = $urandom_range(0, 999);
			2: v = $urandom_range(0, 99999);
			3: begin
				repeat ($urandom_range(9)) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
			end
			default: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = fpdf_pkg::MAG_MAX;
					2: v = 32'h8000_0001;
					default: v = '0;
				endcase
			end
		endcase
		if (kind >= 1 && kind <= 3 && $urandom_range(1))
			v = ~v + 32'd1;
		return v;
	endfunction

	function automatic logic [fpdf_pkg::DEC_W-1:0] rand_places();
		if ($urandom_range(9) == 0)
			return fpdf_pkg::DEC_W'($urandom_range(fpdf_pkg::MAX_DECIMALS + 1, 15));
		return fpdf_pkg::DEC_W'($urandom_range(0, fpdf_pkg::MAX_DECIMALS));
	endfunction

	task automatic run_random(int count);
		repeat (count) send_number(rand_value(), rand_places());
	endtask

	// Receiver: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_len = hold_req;
			hold_req = 0;
			chr_if.ready <= 1'b0;
			repeat (hold_len) @(posedge clk);
		end else begin
			chr_if.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && chr_if.valid && chr_if.ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char expected none got %h last %b",
					$time, chr_if.char_out, chr_if.last);
				fail_cnt++;
			end else begin
				if (chr_if.char_out !== expected_chars[0].ch) begin
					$display("%0t: char expected %h got %h",
						$time, expected_chars[0].ch, chr_if.char_out);
					fail_cnt++;
				end
				if (chr_if.last !== expected_chars[0].last) begin
					$display("%0t: last expected %b got %b",
						$time, expected_chars[0].last, chr_if.last);
					fail_cnt++;
				end
				void'(expected_chars.pop_front());
			end
		end
	end

	task automatic test_directed();
		in_idle_pct = 0;
		out_stall_pct = 0;
		send_number(32'sd0, 4'd0);
		send_number(32'sd0, 4'd1);
		send_number(32'sd0, 4'd10);
		send_number(32'sd1, 4'd0);
		send_number(-32'sd1, 4'd0);
		send_number(-32'sd1, 4'd3);
		send_number(32'sh7FFF_FFFF, 4'd0);
		send_number(32'sh7FFF_FFFF, 4'd10);
		send_number(32'sh7FFF_FFFF, 4'd9);
		send_number(32'sh8000_0000, 4'd0);
		send_number(32'sh8000_0000, 4'd5);
		send_number(32'sh8000_0000, 4'd10);
		send_number(-32'sd2147483647, 4'd10);
		send_number(32'sd123456, 4'd15);
		send_number(32'sd123456, 4'd11);
		send_number(-32'sd5, 4'd2);
		send_number(32'sd9, 4'd1);
		send_number(32'sd10, 4'd1);
		send_number(32'sd1000000000, 4'd9);
		send_number(-32'sd999999999, 4'd9);
		send_number(32'sd42, 4'd4);
		send_number(32'shAAAA_AAAA, 4'd7);
		send_number(32'sh5555_5555, 4'd6);
		send_number(32'sd100, 4'd2);
		send_number(32'sd7, 4'd8);
	endtask

	task automatic test_no_idle();
		in_idle_pct = 0;
		out_stall_pct = 0;
		run_random(80);
	endtask

	task automatic test_sender_idle();
		in_idle_pct = 67;
		out_stall_pct = 0;
		run_random(80);
	endtask

	task automatic test_receiver_stall();
		in_idle_pct = 0;
		out_stall_pct = 67;
		run_random(80);
	endtask

	task automatic test_both_idle();
		in_idle_pct = 31;
		out_stall_pct = 31;
		run_random(80);
	endtask

	// chars held off long enough that number.ready must drop
	task automatic test_input_stall();
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_req = 300;
		repeat (6) send_number(rand_value(),
			fpdf_pkg::DEC_W'($urandom_range(0, fpdf_pkg::MAX_DECIMALS)));
	endtask

	initial begin
		arst_n          = 1'b0;
		num_if.valid    = 1'b0;
		num_if.value    = '0;
		num_if.decimals = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_input_stall();
		num_if.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("fixed_point_decimal_formatter_top: match");
		end else begin
			$display("fixed_point_decimal_formatter_top: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/fpdf_pkg.sv
rtl/fpdf_in_if.sv
rtl/fpdf_out_if.sv
rtl/fpdf_div10.sv
rtl/fixed_point_decimal_formatter_top.sv
rtl/fpdf_checker.sv
tb/sv/fixed_point_decimal_formatter_top_tb.sv
